### sv/s20rng_pkg.sv
// package: salsa20 constants, types and helpers for the random word generator
package s20rng_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned KeyW = 64;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned NumWords = 16;
	localparam int unsigned RoundsDefault = 20;

	localparam logic [CfgIdxW-1:0] CfgKey0 = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgKey1 = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgKey2 = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgKey3 = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgNonce = 3'd4;

	localparam logic [WordW-1:0] Sigma0 = 32'h61707865;
	localparam logic [WordW-1:0] Sigma1 = 32'h3320646e;
	localparam logic [WordW-1:0] Sigma2 = 32'h79622d32;
	localparam logic [WordW-1:0] Sigma3 = 32'h6b206574;

	localparam logic [0:0] CmdRaw = 1'b0;
	localparam logic [0:0] CmdUniform = 1'b1;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [NumWords-1:0] state_t;

	function automatic word_t rotl(input word_t v, input int unsigned n);
		rotl = (v << n) | (v >> (WordW - n));
	endfunction

endpackage

### sv/salsa20_random_word_generator_unit.sv
// top level: salsa20/20 keystream random word generator with uniform draws
//
// channel  direction  signals
// request  in         in_valid, in_ready, cmd, bound
// result   out        out_valid, out_ready, value
// config   in         cfg_we, cfg_index, cfg_data
//
// each column or row round runs four parallel quarter rounds as one registered step;
// a block serves 16 words
// a raw request is answered from the draw state when a word is buffered
// a uniform request first finds 2^32 mod bound (leading one, then one bit a cycle),
// then draws words until one is not below it and divides that word for the remainder
// reset clears the buffer count and loads the nonce counter with 1
// the result register is held until taken; no request is accepted meanwhile
module salsa20_random_word_generator_unit #(
	parameter int unsigned Rounds = s20rng_pkg::RoundsDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [s20rng_pkg::WordW-1:0]        bound,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [s20rng_pkg::WordW-1:0]        value,
	input  logic                                cfg_we,
	input  logic [s20rng_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [s20rng_pkg::KeyW-1:0]         cfg_data
);
	import s20rng_pkg::*;

	localparam int unsigned DRounds = Rounds / 2;
	localparam int unsigned RndW = $clog2(DRounds + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DRAW, ST_ROUND, ST_FINAL, ST_LO, ST_MOD, ST_OUT
	} fsm_t;

	fsm_t st_q;
	logic [KeyW-1:0] key_q [4];
	logic [KeyW-1:0] nonce_q;
	logic [4:0] left_q;
	state_t blk_q, x_q;
	logic phase_q;
	logic [RndW-1:0] rnd_q;
	logic cmd_q;
	word_t bound_q, lo_q, rem_q, quo_q;
	logic [5:0] bit_q;
	logic lo_done_q;
	logic out_valid_q;
	word_t value_q;

	state_t init_w, x_n;
	word_t w_sel;

	always_comb begin
		init_w[0] = Sigma0;
		init_w[5] = Sigma1;
		init_w[10] = Sigma2;
		init_w[15] = Sigma3;
		init_w[1] = key_q[0][31:0];
		init_w[2] = key_q[0][63:32];
		init_w[3] = key_q[1][31:0];
		init_w[4] = key_q[1][63:32];
		init_w[11] = key_q[2][31:0];
		init_w[12] = key_q[2][63:32];
		init_w[13] = key_q[3][31:0];
		init_w[14] = key_q[3][63:32];
		init_w[6] = nonce_q[31:0];
		init_w[7] = nonce_q[63:32];
		init_w[8] = '0;
		init_w[9] = '0;
	end

	function automatic state_t qr(input state_t s, input int a, input int b,
			input int c, input int d);
		state_t t;
		t = s;
		t[b] = t[b] ^ rotl(t[a] + t[d], 7);
		t[c] = t[c] ^ rotl(t[b] + t[a], 9);
		t[d] = t[d] ^ rotl(t[c] + t[b], 13);
		t[a] = t[a] ^ rotl(t[d] + t[c], 18);
		return t;
	endfunction

	always_comb begin
		x_n = x_q;
		if (!phase_q) begin
			x_n = qr(x_n, 0, 4, 8, 12);
			x_n = qr(x_n, 5, 9, 13, 1);
			x_n = qr(x_n, 10, 14, 2, 6);
			x_n = qr(x_n, 15, 3, 7, 11);
		end else begin
			x_n = qr(x_n, 0, 1, 2, 3);
			x_n = qr(x_n, 5, 6, 7, 4);
			x_n = qr(x_n, 10, 11, 8, 9);
			x_n = qr(x_n, 15, 12, 13, 14);
		end
	end

	assign w_sel = blk_q[left_q[3:0] - 4'd1];

	// shared restoring division step
	logic [WordW:0] rem_sh;
	logic [WordW:0] rem_sub;
	always_comb begin
		// dividend bits: for 2^32 mod b a leading one then zeros, else the drawn word
		rem_sh = {rem_q, (lo_done_q ? quo_q[WordW-1] : 1'b0)};
		rem_sub = rem_sh - {1'b0, bound_q};
	end

	assign in_ready = (st_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce_q <= 64'd1;
			left_q <= '0;
			out_valid_q <= 1'b0;
			phase_q <= 1'b0;
			rnd_q <= '0;
			bit_q <= '0;
			lo_done_q <= 1'b0;
			blk_q <= '0;
			x_q <= '0;
			cmd_q <= CmdRaw;
			bound_q <= '0;
			lo_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			value_q <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index) inside
					CfgKey0, CfgKey1, CfgKey2, CfgKey3: begin
						key_q[cfg_index[1:0]] <= cfg_data;
						left_q <= '0;
					end
					CfgNonce: nonce_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= cmd;
						bound_q <= bound;
						if (cmd == CmdRaw) begin
							st_q <= ST_DRAW;
						end else if (bound < 32'd2) begin
							value_q <= '0;
							out_valid_q <= 1'b1;
						end else begin
							rem_q <= '0;
							bit_q <= 6'd33;
							lo_done_q <= 1'b0;
							st_q <= ST_LO;
						end
					end
				end
				ST_LO: begin
					// dividend 2^32: 33 bits, top one then zeros
					if (bit_q == 6'd33) begin
						rem_q <= 32'd1;
						bit_q <= bit_q - 6'd1;
					end else begin
						rem_q <= rem_sub[WordW] ? rem_sh[WordW-1:0] : rem_sub[WordW-1:0];
						bit_q <= bit_q - 6'd1;
						if (bit_q == 6'd1) begin
							lo_done_q <= 1'b1;
							st_q <= ST_DRAW;
						end
					end
				end
				ST_DRAW: begin
					if (left_q == 5'd0) begin
						x_q <= init_w;
						phase_q <= 1'b0;
						rnd_q <= '0;
						st_q <= ST_ROUND;
					end else begin
						left_q <= left_q - 5'd1;
						if (cmd_q == CmdRaw) begin
							value_q <= w_sel;
							out_valid_q <= 1'b1;
							st_q <= ST_IDLE;
						end else if (w_sel < lo_q) begin
							st_q <= ST_DRAW;
						end else begin
							quo_q <= w_sel;
							rem_q <= '0;
							bit_q <= 6'd32;
							st_q <= ST_MOD;
						end
					end
				end
				ST_ROUND: begin
					x_q <= x_n;
					phase_q <= !phase_q;
					if (phase_q) begin
						rnd_q <= rnd_q + RndW'(1);
						if (rnd_q == RndW'(DRounds - 1)) st_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < NumWords; i++) blk_q[i] <= x_q[i] + init_w[i];
					nonce_q <= nonce_q + 64'd1;
					left_q <= 5'd16;
					st_q <= ST_DRAW;
				end
				ST_MOD: begin
					rem_q <= rem_sub[WordW] ? rem_sh[WordW-1:0] : rem_sub[WordW-1:0];
					quo_q <= {quo_q[WordW-2:0], 1'b0};
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd1) st_q <= ST_OUT;
				end
				ST_OUT: begin
					value_q <= rem_q;
					out_valid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q == ST_LO && bit_q == 6'd1)
				lo_q <= rem_sub[WordW] ? rem_sh[WordW-1:0] : rem_sub[WordW-1:0];
		end
	end
endmodule

### verif/tb_top.sv
// salsa20 random word generator bench: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb_top;
	import s20rng_pkg::*;

	typedef struct packed {
		logic  kind;
		word_t bound;
	} request_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                cmd = CmdRaw;
	logic [WordW-1:0]    bound = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [WordW-1:0]    value;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = CfgKey0;
	logic [KeyW-1:0]     cfg_data = '0;

	salsa20_random_word_generator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .bound(bound),
		.out_valid(out_valid), .out_ready(out_ready), .value(value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [KeyW-1:0] key_reg [4];
	logic [KeyW-1:0] nonce_ctr;
	word_t           stream_words [NumWords];
	int unsigned     stream_left;

	request_t    pending_requests[$];
	word_t       expected_values[$];
	int unsigned errors = 0;
	int unsigned n_raw = 0, n_uniform = 0, n_results = 0, n_redraws = 0, n_blocks = 0;
	int unsigned in_gap = 0, out_gap = 0, idle_cycles = 0;
	bit          calm = 1'b0;
	request_t    item;

	function automatic word_t rl(word_t v, int unsigned n);
		logic [2*WordW-1:0] twice;
		twice = {v, v} << n;
		return twice[2*WordW-1:WordW];
	endfunction

	function automatic void mix(inout word_t a, inout word_t b, inout word_t c, inout word_t d);
		b ^= rl(a + d, 7);
		c ^= rl(b + a, 9);
		d ^= rl(c + b, 13);
		a ^= rl(d + c, 18);
	endfunction

	task automatic refill_stream();
		word_t init [NumWords];
		word_t x [NumWords];
		init[0] = Sigma0;  init[5] = Sigma1;  init[10] = Sigma2;  init[15] = Sigma3;
		init[1] = key_reg[0][31:0];  init[2] = key_reg[0][63:32];
		init[3] = key_reg[1][31:0];  init[4] = key_reg[1][63:32];
		init[11] = key_reg[2][31:0]; init[12] = key_reg[2][63:32];
		init[13] = key_reg[3][31:0]; init[14] = key_reg[3][63:32];
		init[6] = nonce_ctr[31:0];   init[7] = nonce_ctr[63:32];
		init[8] = '0;                init[9] = '0;
		x = init;
		for (int r = 0; r < 10; r++) begin
			mix(x[0], x[4], x[8], x[12]);
			mix(x[5], x[9], x[13], x[1]);
			mix(x[10], x[14], x[2], x[6]);
			mix(x[15], x[3], x[7], x[11]);
			mix(x[0], x[1], x[2], x[3]);
			mix(x[5], x[6], x[7], x[4]);
			mix(x[10], x[11], x[8], x[9]);
			mix(x[15], x[12], x[13], x[14]);
		end
		for (int i = 0; i < NumWords; i++)
			stream_words[i] = x[i] + init[i];
		nonce_ctr += 1;
		stream_left = NumWords;
		n_blocks++;
	endtask

	task automatic next_word(output word_t w);
		if (stream_left == 0)
			refill_stream();
		stream_left--;
		w = stream_words[stream_left];
	endtask

	task automatic predict_value(input request_t req, output word_t res);
		word_t floor_val;
		if (req.kind == CmdRaw) begin
			next_word(res);
			n_raw++;
		end else begin
			n_uniform++;
			if (req.bound < 2) begin
				res = '0;
			end else begin
				floor_val = (32'd0 - req.bound) % req.bound;
				next_word(res);
				while (res < floor_val) begin
					n_redraws++;
					next_word(res);
				end
				res = res % req.bound;
			end
		end
	endtask

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				word_t res;
				predict_value('{cmd, bound}, res);
				expected_values.push_back(res);
			end
			if (in_gap > 0)
				in_gap--;
			else if (!calm && $urandom_range(0, 7) == 0)
				in_gap = $urandom_range(1, 10);
			if (in_gap == 0 && pending_requests.size() > 0) begin
				item = pending_requests.pop_front();
				cmd <= item.kind;
				bound <= item.bound;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_values.size() == 0)
					report($sformatf("unexpected result %h", value));
				else begin
					word_t exp_v;
					exp_v = expected_values.pop_front();
					if (value !== exp_v)
						report($sformatf("value %h, predicted %h", value, exp_v));
				end
			end
			if (out_gap > 0)
				out_gap--;
			else if (!calm && $urandom_range(0, 7) == 0)
				out_gap = $urandom_range(1, 10);
			out_ready <= (out_gap == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 20000) begin
			$display("watchdog expired");
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx <= CfgKey3) begin
			key_reg[idx[1:0]] = data;
			stream_left = 0;
		end else if (idx == CfgNonce) begin
			nonce_ctr = data;
		end
	endtask

	task automatic writes_done();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_request(input logic k, input word_t b);
		pending_requests.push_back('{k, b});
	endtask

	task automatic add_random(input int unsigned count);
		word_t b;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: b = $urandom_range(0, 20);
				1: b = $urandom;
				2: b = 32'h8000_0000 | $urandom;
				default: b = 32'h8000_0000 + $urandom_range(0, 64);
			endcase
			add_request($urandom_range(0, 1) ? CmdUniform : CmdRaw, b);
		end
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || in_valid || expected_values.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_key();
		reg_write(CfgKey0, {$urandom, $urandom});
		reg_write(CfgKey1, {$urandom, $urandom});
		reg_write(CfgKey2, {$urandom, $urandom});
		reg_write(CfgKey3, {$urandom, $urandom});
	endtask

	initial begin
		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		nonce_ctr = 64'd1;
		stream_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests under reset settings
		add_request(CmdRaw, '0);
		add_request(CmdRaw, '1);
		add_request(CmdUniform, 32'd0);
		add_request(CmdUniform, 32'd1);
		add_request(CmdUniform, 32'd2);
		add_request(CmdUniform, 32'd3);
		add_request(CmdUniform, 32'hffff_ffff);
		add_request(CmdUniform, 32'h8000_0000);
		add_request(CmdUniform, 32'h8000_0001);
		add_request(CmdUniform, 32'h7fff_ffff);
		add_request(CmdUniform, 32'h5555_5555);
		add_request(CmdUniform, 32'haaaa_aaaa);
		for (int i = 0; i < 10; i++)
			add_request(CmdRaw, 32'h1234_5678);
		drain();

		// all-ones key, nonce about to wrap
		for (int i = 0; i < 4; i++)
			reg_write(i[CfgIdxW-1:0], '1);
		reg_write(CfgNonce, '1);
		writes_done();
		for (int i = 0; i < 40; i++)
			add_request(CmdRaw, '0);
		add_random(120);
		drain();

		// zero key, zero nonce, ignored register indexes
		for (int i = 0; i < 4; i++)
			reg_write(i[CfgIdxW-1:0], '0);
		reg_write(CfgNonce, '0);
		reg_write(3'd5, '1);
		reg_write(3'd6, {$urandom, $urandom});
		reg_write(3'd7, '1);
		writes_done();
		add_random(160);
		drain();

		// nonce change only, buffered words stay
		reg_write(CfgNonce, {$urandom, $urandom});
		writes_done();
		add_random(160);
		drain();

		random_key();
		reg_write(CfgNonce, {$urandom, $urandom});
		writes_done();
		add_random(160);
		drain();

		// single key word change mid-buffer
		reg_write(CfgKey2, {$urandom, $urandom});
		writes_done();
		add_random(150);
		drain();

		calm = 1'b1;
		random_key();
		writes_done();
		add_random(140);
		drain();

		$display("requests: %0d raw, %0d uniform; %0d results checked", n_raw, n_uniform,
			n_results);
		$display("keystream blocks: %0d, rejected draws: %0d, mismatches: %0d", n_blocks,
			n_redraws, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
